// ===== rtl/smsp_pkg.sv =====
// shared types and constants for the shuffled minimal-standard generator
package smsp_pkg;

  // value and field widths
  localparam int unsigned VAL_W      = 31;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned MUL_W      = 15;
  localparam int unsigned PROD_W     = VAL_W + MUL_W;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 56;

  // lehmer multiplier and prime modulus 2^31-1
  localparam logic [MUL_W-1:0]  LEHMER_MUL = 15'd16807;
  localparam logic [VAL_W-1:0]  LEHMER_MOD = 31'h7FFF_FFFF;

  // largest fraction code, two lsb below one
  localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;       // transaction accepted, latch seed if seeding
    logic mul;        // multiply generator by the lehmer constant
    logic div_start;  // start slot computation from the last output
    logic red_fill;   // reduce product, fill table entry during seeding
    logic red_draw;   // reduce product for a draw
    logic wb;         // swap table slot, update last output, load result
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_seed;  // reseed asked for or table not yet loaded
    logic cnt_zero;   // last seeding step in progress
    logic div_busy;   // slot computation still running
    logic out_free;   // result register can take a new value
  } status_t;

endpackage

// ===== rtl/smsp_ram.sv =====
// simple dual-port ram with registered read
module smsp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/smsp_slot_div.sv =====
// slot index by reciprocal multiply and one correction step
module smsp_slot_div #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [smsp_pkg::VAL_W-1:0]    dividend,
  output logic                          busy,
  output logic [$clog2(TABLE_SIZE)-1:0] quot
);

  localparam int unsigned     VAL_W    = smsp_pkg::VAL_W;
  localparam int unsigned     SLOT_W   = $clog2(TABLE_SIZE);
  localparam longint unsigned SLOT_DIV = 64'd1 + 64'h7FFF_FFFE / 64'(TABLE_SIZE);
  localparam longint unsigned RECIP    = (64'd1 << 32) / SLOT_DIV;
  localparam int unsigned     RCP_W    = $clog2(RECIP + 1);
  localparam int unsigned     PROD_W   = VAL_W + RCP_W;

  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  x_r;
  logic [SLOT_W-1:0] est_r;
  logic [SLOT_W-1:0] quot_r, quot_nxt;
  logic              fix_r, fix_nxt;
  logic [VAL_W:0]    back;
  logic [VAL_W:0]    rem;

  // estimate from the truncated reciprocal, at most one below the quotient
  assign prod = PROD_W'(dividend) * PROD_W'(RECIP);

  // correction: bump the estimate when a whole slot width is left over
  always_comb begin
    back     = (VAL_W+1)'(est_r) * (VAL_W+1)'(SLOT_DIV);
    rem      = {1'b0, x_r} - back;
    quot_nxt = quot_r;
    fix_nxt  = 1'b0;
    if (start) begin
      fix_nxt = 1'b1;
    end else if (fix_r) begin
      quot_nxt = est_r + SLOT_W'(rem >= (VAL_W+1)'(SLOT_DIV));
    end
  end

  // pending correction is control state, the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_r <= 1'b0;
    end else begin
      fix_r <= fix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      est_r <= SLOT_W'(prod[PROD_W-1:32]);
    end
    quot_r <= quot_nxt;
  end

  assign busy = fix_r;
  assign quot = quot_r;

endmodule

// ===== rtl/smsp_datapath.sv =====
// generator, shuffle table, slot divider and result register
module smsp_datapath #(
  parameter int unsigned TABLE_SIZE   = 32,
  parameter int unsigned WARMUP_STEPS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smsp_pkg::cmd_t                     cmd,
  output smsp_pkg::status_t                  status,
  input  logic [smsp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [smsp_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int unsigned VAL_W  = smsp_pkg::VAL_W;
  localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);
  localparam int unsigned STEPS  = TABLE_SIZE + WARMUP_STEPS;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  logic [VAL_W-1:0]                 gen_r, gen_nxt;
  logic [VAL_W-1:0]                 last_r, last_nxt;
  logic [smsp_pkg::PROD_W-1:0]      mul_r;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [smsp_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [VAL_W-1:0]                 seed;
  logic [VAL_W-1:0]                 seed_x0;
  logic [VAL_W:0]                   fold;
  logic [VAL_W-1:0]                 red;
  logic [SLOT_W-1:0]                quot;
  logic [SLOT_W-1:0]                slot;
  logic                             div_busy;
  logic                             ram_we;
  logic [SLOT_W-1:0]                ram_waddr;
  logic [VAL_W-1:0]                 ram_wdata;
  logic [VAL_W-1:0]                 ram_rdata;
  logic [smsp_pkg::FRAC_W-1:0]      frac;
  logic                             fill_hit;

  // seed fix-up: zero, the modulus itself and a seeding draw all start from one
  assign seed = in_tdata[VAL_W-1:0];
  always_comb begin
    seed_x0 = VAL_W'(1);
    if (in_tuser && seed != '0 && seed != smsp_pkg::LEHMER_MOD) begin
      seed_x0 = seed;
    end
  end

  // mod 2^31-1 by folding the high bits onto the low bits
  always_comb begin
    fold = {1'b0, mul_r[VAL_W-1:0]} + (VAL_W+1)'(mul_r[smsp_pkg::PROD_W-1:VAL_W]);
    if (fold >= {1'b0, smsp_pkg::LEHMER_MOD}) begin
      fold = fold - {1'b0, smsp_pkg::LEHMER_MOD};
    end
    red = fold[VAL_W-1:0];
  end

  // slot divider, quotient never reaches the table size but is clamped anyway
  smsp_slot_div #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (last_r),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign slot = (32'(quot) >= TABLE_SIZE) ? SLOT_W'(TABLE_SIZE - 1) : quot;

  // table write: the last TABLE_SIZE seeding steps fill every entry, a draw refills the used slot
  assign fill_hit  = cmd.red_fill && (32'(cnt_r) < TABLE_SIZE);
  assign ram_we    = fill_hit || cmd.wb;
  assign ram_waddr = cmd.wb ? slot : cnt_r[SLOT_W-1:0];
  assign ram_wdata = cmd.wb ? gen_r : red;

  smsp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // q0.24 fraction: with a 2^31-1 divisor the quotient is just the top bits
  assign frac = (ram_rdata[VAL_W-1:7] > smsp_pkg::FRAC_MAX) ? smsp_pkg::FRAC_MAX
                                                             : ram_rdata[VAL_W-1:7];

  // next state of generator, last output, step count and result flag
  always_comb begin
    gen_nxt       = gen_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.take && status.need_seed) begin
      gen_nxt = seed_x0;
      cnt_nxt = CNT_W'(STEPS - 1);
    end
    if (cmd.red_fill) begin
      gen_nxt = red;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        last_nxt = red;
      end
    end
    if (cmd.red_draw) begin
      gen_nxt = red;
    end
    if (cmd.wb) begin
      last_nxt      = ram_rdata;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= VAL_W'(1);
      last_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gen_r       <= gen_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // product register and result payload
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mul_r <= gen_r * smsp_pkg::LEHMER_MUL;
    end
    if (cmd.wb) begin
      out_data_r <= {1'b0, frac, ram_rdata};
    end
  end

  assign status.need_seed = in_tuser || (last_r == '0);
  assign status.cnt_zero  = (cnt_r == '0);
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the generator can never fall to zero
  assert property (@(posedge clk) disable iff (!rst_n) gen_r != '0)
    else $error("generator reached zero");

  // a draw only swaps once its slot is final
  assert property (@(posedge clk) disable iff (!rst_n) cmd.wb |-> !div_busy)
    else $error("table swap before slot was ready");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk) disable iff (!rst_n) cmd.wb |-> status.out_free)
    else $error("result register overwritten");

  // after a draw the table is marked loaded and the result is presented
  assert property (@(posedge clk) disable iff (!rst_n)
                   cmd.wb |=> (out_valid_r && last_r != '0))
    else $error("draw left no valid result or cleared last output");

endmodule

// ===== rtl/smsp_ctrl.sv =====
// controller: sequences seeding steps and the draw
module smsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  smsp_pkg::status_t status,
  output smsp_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL_MUL,
    S_FILL_RED,
    S_DRAW_MUL,
    S_DRAW_RED,
    S_DRAW_DIV,
    S_DRAW_WB
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;
  logic   accept;

  assign accept = in_tvalid && ready_r;

  // commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (status.need_seed) begin
            state_nxt = S_FILL_MUL;
          end else begin
            cmd.mul       = 1'b1;
            cmd.div_start = 1'b1;
            state_nxt     = S_DRAW_RED;
          end
        end
      end
      S_FILL_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FILL_RED;
      end
      S_FILL_RED: begin
        cmd.red_fill = 1'b1;
        state_nxt    = S_FILL_MUL;
        if (status.cnt_zero) begin
          // last seeding step: the draw multiplies the fresh generator next
          state_nxt = S_DRAW_MUL;
        end
      end
      S_DRAW_MUL: begin
        cmd.mul       = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DRAW_RED;
      end
      S_DRAW_RED: begin
        cmd.red_draw = 1'b1;
        state_nxt    = S_DRAW_DIV;
      end
      S_DRAW_DIV: begin
        if (!status.div_busy) begin
          state_nxt = S_DRAW_WB;
        end
      end
      S_DRAW_WB: begin
        if (status.out_free) begin
          cmd.wb    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ready_nxt = (state_nxt == S_IDLE);

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_tready = ready_r;

  // ready tracks the idle state
  assert property (@(posedge clk) disable iff (!rst_n) ready_r == (state_r == S_IDLE))
    else $error("ready out of step with idle state");

  // a draw never writes back without first waiting on the divider state
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_DRAW_WB) |-> ($past(state_r) == S_DRAW_DIV ||
                                               $past(state_r) == S_DRAW_WB))
    else $error("write-back entered out of sequence");

  // seeding always ends in a draw
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_FILL_RED && status.cnt_zero) |=> state_r == S_DRAW_MUL)
    else $error("seeding did not lead into a draw");

endmodule

// ===== rtl/shuffled_minimal_standard_prng.sv =====
// top level of the shuffled minimal-standard uniform generator
//
// channel  dir  handshake             payload
// in       in   in_tvalid/in_tready   in_tuser = func, in_tdata[30:0] = seed
// out      out  out_tvalid/out_tready out_tdata[30:0] = sample, [54:31] = fraction
//
// a draw runs lehmer multiply with the slot estimate, modular fold with the slot
// correction, table read, then write-back; the result is registered at write-back
// and the next transaction is taken after write-back.
// a reseed, and the first draw after reset, first runs TABLE_SIZE+WARMUP_STEPS
// generator steps, each a multiply then a modular fold, plus an extra multiply
// state. reset is synchronous and active low; the shuffle table is not cleared,
// since seeding writes every entry before any read.
// the result register lets a new transaction be accepted while a result waits;
// its draw then holds in write-back until out_tready frees the register.
module shuffled_minimal_standard_prng #(
  parameter int unsigned TABLE_SIZE   = 32,
  parameter int unsigned WARMUP_STEPS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [smsp_pkg::IN_DATA_W-1:0]  in_tdata,   // [30:0] seed, [31] zero
  input  logic                            in_tuser,   // [0] func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [30:0] sample, [54:31] fraction, [55] zero
  output logic [smsp_pkg::OUT_DATA_W-1:0] out_tdata
);

  smsp_pkg::cmd_t    cmd;
  smsp_pkg::status_t status;

  smsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  smsp_datapath #(
    .TABLE_SIZE   (TABLE_SIZE),
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/tb_shuffled_minimal_standard_prng.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the shuffled minimal-standard generator
module tb_shuffled_minimal_standard_prng;

  localparam int unsigned VAL_W        = smsp_pkg::VAL_W;
  localparam int unsigned FRAC_W       = smsp_pkg::FRAC_W;
  localparam int unsigned TABLE_SIZE   = 32;
  localparam int unsigned WARMUP_STEPS = 8;
  localparam int unsigned SLOT_SPAN    = 1 + (smsp_pkg::LEHMER_MOD - 1) / TABLE_SIZE;
  localparam int          MAX_REPORTS  = 10;
  localparam int          IDLE_PCT     = 9;

  typedef enum logic {
    FUNC_DRAW   = 1'b0,
    FUNC_RESEED = 1'b1
  } func_t;

  typedef struct packed {
    logic [VAL_W-1:0]  sample;
    logic [FRAC_W-1:0] fraction;
  } draw_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [smsp_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [smsp_pkg::OUT_DATA_W-1:0] out_tdata;

  // predictor state
  logic [VAL_W-1:0] gen_state   = VAL_W'(1);
  logic [VAL_W-1:0] last_sample = '0;
  logic [VAL_W-1:0] shuffle_slots [TABLE_SIZE];

  draw_t pending_draws [$];
  int    mismatch_count = 0;
  bit    no_gaps        = 1'b0;
  int    hold_request   = 0;

  shuffled_minimal_standard_prng #(
    .TABLE_SIZE   (TABLE_SIZE),
    .WARMUP_STEPS (WARMUP_STEPS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // one lehmer step, x*16807 mod 2^31-1
  function automatic logic [VAL_W-1:0] lehmer_step(input logic [VAL_W-1:0] x);
    longint unsigned prod;
    prod = x;
    prod = prod * smsp_pkg::LEHMER_MUL;
    return VAL_W'(prod % smsp_pkg::LEHMER_MOD);
  endfunction

  // seed, warm up and load the shuffle table
  function automatic void seed_table(input logic [VAL_W-1:0] start);
    logic [VAL_W-1:0] x;
    x = (start == smsp_pkg::LEHMER_MOD) ? '0 : start;
    if (x == '0) x = VAL_W'(1);
    for (int n = TABLE_SIZE + WARMUP_STEPS - 1; n >= 0; n--) begin
      x = lehmer_step(x);
      if (n < TABLE_SIZE) shuffle_slots[n] = x;
    end
    gen_state   = x;
    last_sample = shuffle_slots[0];
  endfunction

  // expected result of one accepted transaction
  function automatic draw_t predict_draw(input func_t f, input logic [VAL_W-1:0] seed);
    int unsigned     slot;
    longint unsigned frac;
    draw_t           d;
    if (f == FUNC_RESEED) seed_table(seed);
    else if (last_sample == '0) seed_table(VAL_W'(1));
    gen_state = lehmer_step(gen_state);
    slot = last_sample / SLOT_SPAN;
    if (slot >= TABLE_SIZE) slot = TABLE_SIZE - 1;
    last_sample = shuffle_slots[slot];
    shuffle_slots[slot] = gen_state;
    frac = last_sample;
    frac = (frac << FRAC_W) / smsp_pkg::LEHMER_MOD;
    if (frac > smsp_pkg::FRAC_MAX) frac = smsp_pkg::FRAC_MAX;
    d.sample   = last_sample;
    d.fraction = FRAC_W'(frac);
    return d;
  endfunction

  // seeds biased toward the edges of the range
  function automatic logic [VAL_W-1:0] random_seed();
    case ($urandom_range(0, 5))
      0:       return VAL_W'($urandom_range(0, 3));
      1:       return smsp_pkg::LEHMER_MOD - VAL_W'($urandom_range(0, 3));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // offer one transaction and record its expected result on acceptance
  task automatic send_item(input func_t f, input logic [VAL_W-1:0] seed);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= smsp_pkg::IN_DATA_W'(seed);
    do @(posedge clk); while (!in_tready);
    pending_draws.push_back(predict_draw(f, seed));
  endtask

  // mostly draws with the odd reseed
  task automatic send_mixed(input int count, input int reseed_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < reseed_pct) send_item(FUNC_RESEED, random_seed());
      else send_item(FUNC_DRAW, VAL_W'($urandom));
    end
  endtask

  // draws right after reset must seed with one and ignore the seed field
  task automatic test_first_draw();
    send_item(FUNC_DRAW, 31'h7FFF_FFFE);
    send_item(FUNC_DRAW, VAL_W'($urandom));
    send_item(FUNC_DRAW, '0);
  endtask

  // zero, one, modulus, top value and alternating bit seeds
  task automatic test_seed_extremes();
    logic [VAL_W-1:0] seeds [6];
    seeds = '{31'd0, 31'd1, smsp_pkg::LEHMER_MOD, smsp_pkg::LEHMER_MOD - 31'd1,
              31'h2AAA_AAAA, 31'h5555_5555};
    foreach (seeds[i]) begin
      send_item(FUNC_RESEED, seeds[i]);
      send_item(FUNC_DRAW, ~seeds[i]);
    end
    // back-to-back reseeds
    send_item(FUNC_RESEED, 31'd12345);
    send_item(FUNC_RESEED, 31'd12345);
  endtask

  task automatic test_random_stream();
    send_mixed(880, 5);
  endtask

  // both sides run without gaps for a while
  task automatic test_gapless_burst();
    no_gaps = 1'b1;
    send_mixed(200, 3);
    no_gaps = 1'b0;
  endtask

  // receiver holds off long enough to back up the input side
  task automatic test_output_stall();
    hold_request = 300;
    send_mixed(80, 2);
  endtask

  // receiver: random stalls, optional long hold
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    draw_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_draws.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: sample %0d fraction %0d",
                   out_tdata[VAL_W-1:0], out_tdata[VAL_W +: FRAC_W]);
      end else begin
        want = pending_draws.pop_front();
        if (out_tdata[VAL_W-1:0] !== want.sample ||
            out_tdata[VAL_W +: FRAC_W] !== want.fraction) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: sample exp %0d got %0d, fraction exp %0d got %0d",
                     want.sample, out_tdata[VAL_W-1:0],
                     want.fraction, out_tdata[VAL_W +: FRAC_W]);
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_draw();
    test_seed_extremes();
    test_random_stream();
    test_gapless_burst();
    test_output_stall();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
